FILE: src/c8x_pkg.sv
// Package for the CHIP-8 instruction execute block.
// Holds opcode codes, the front-to-back command struct and back-end states; no dependencies.
package c8x_pkg;

  // Size of the addressed memory; addresses wrap at this boundary.
  localparam int MEMORY_WORDS = 4096;

  // Major opcode nibbles.
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SE   = 4'h3;
  localparam logic [3:0] OP_SNE  = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LD   = 4'h6;
  localparam logic [3:0] OP_ADD  = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_MISC = 4'hF;

  // ALU sub-codes of 8xyn.
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // Fxkk low-byte codes.
  localparam logic [7:0] MISC_HALT = 8'h00;
  localparam logic [7:0] MISC_GDT  = 8'h07;
  localparam logic [7:0] MISC_SDT  = 8'h15;
  localparam logic [7:0] MISC_ADDI = 8'h1E;
  localparam logic [7:0] MISC_BCD  = 8'h33;
  localparam logic [7:0] MISC_STR  = 8'h55;

  localparam logic [11:0] RET_NNN     = 12'h0EE;
  localparam logic [7:0]  RANDOM_INIT = 8'h23;
  localparam logic [7:0]  HUNDRED     = 8'd100;
  localparam logic [7:0]  TWO_HUNDRED = 8'd200;
  localparam logic [7:0]  TEN         = 8'd10;

  // Division by ten of a value below 100 as a multiply by 205 and a shift by 11.
  localparam logic [14:0] TEN_RECIP = 15'd205;
  localparam int          TEN_SHIFT = 11;

  // Register indexes of the configuration port.
  localparam logic CFG_START  = 1'b0;
  localparam logic CFG_RANDOM = 1'b1;

  // Classified instruction handed from front to back.
  typedef struct packed {
    logic [15:0] word;
    logic        undef;
  } c8x_cmd_t;

  typedef enum logic [1:0] {
    ST_EXEC,
    ST_BCD,
    ST_STORE
  } c8x_state_t;

endpackage

FILE: src/c8x_front.sv
// Front end: accepts instruction words, flags undefined codes, and queues them.
// Depends on c8x_pkg.
module c8x_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       instruction_word,
  output logic              q_valid,
  output c8x_pkg::c8x_cmd_t q_cmd,
  input  logic              q_pop
);

  // Two-entry queue.
  c8x_pkg::c8x_cmd_t slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  logic       undef;

  // Classify the word.
  always_comb begin
    undef = 1'b0;
    unique case (instruction_word[15:12])
      c8x_pkg::OP_SYS: undef = (instruction_word[11:0] != c8x_pkg::RET_NNN);
      c8x_pkg::OP_ALU: begin
        case (instruction_word[3:0])
          c8x_pkg::ALU_MOV, c8x_pkg::ALU_OR, c8x_pkg::ALU_AND, c8x_pkg::ALU_XOR,
          c8x_pkg::ALU_ADD, c8x_pkg::ALU_SUB, c8x_pkg::ALU_SHR, c8x_pkg::ALU_SBN,
          c8x_pkg::ALU_SHL: undef = 1'b0;
          default: undef = 1'b1;
        endcase
      end
      c8x_pkg::OP_MISC: begin
        case (instruction_word[7:0])
          c8x_pkg::MISC_HALT, c8x_pkg::MISC_GDT, c8x_pkg::MISC_SDT,
          c8x_pkg::MISC_ADDI, c8x_pkg::MISC_BCD, c8x_pkg::MISC_STR: undef = 1'b0;
          default: undef = 1'b1;
        endcase
      end
      4'hD, 4'hE: undef = 1'b1;
      default: undef = 1'b0;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slots[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{word: instruction_word, undef: undef};
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: src/c8x_back.sv
// Back end: executes queued instructions against the register file and emits results.
// Depends on c8x_pkg.
module c8x_back #(
  parameter int STACK_DEPTH  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  c8x_pkg::c8x_cmd_t q_cmd,
  output logic              q_pop,
  input  logic              cfg_start_we,
  input  logic [11:0]       cfg_start,
  input  logic [7:0]        random_stand_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       next_pc,
  output logic              halted,
  output logic              write_valid,
  output logic [11:0]       write_address,
  output logic [7:0]        write_data,
  output logic              not_executed,
  output logic              last
);

  localparam int AW = $clog2(c8x_pkg::MEMORY_WORDS);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [AW-1:0] AMASK = AW'(c8x_pkg::MEMORY_WORDS - 1);

  // Architectural state.
  logic [7:0]    vreg [16];
  logic [11:0]   ireg;
  logic [11:0]   pc;
  logic [11:0]   rstack [STACK_DEPTH];
  logic [SW-1:0] sp;
  logic [7:0]    dtimer;
  logic          halt;

  // Multi-result sequencing.
  c8x_pkg::c8x_state_t state, state_next;
  logic [3:0]  cnt;
  logic [3:0]  cnt_end;
  logic [7:0]  bcd_val;
  logic [11:0] run_pc;

  // Output register.
  logic out_full;
  logic can_emit;
  assign out_valid = out_full;
  assign can_emit  = !out_full || !out_stall;

  logic [3:0]  op, x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn, pc1, pc2, nxt;
  logic [8:0]  sum9;
  logic [SW-1:0] sp_dec;
  logic [SW-1:0] sp_inc;
  logic        exec_go;
  logic        exec_halt;
  logic [7:0]  alu_res;
  logic        alu_flag;
  logic        alu_wf;
  logic [1:0]  bcd_hund;
  logic [7:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_tens;
  logic [3:0]  bcd_ones;

  assign op  = q_cmd.word[15:12];
  assign x   = q_cmd.word[11:8];
  assign y   = q_cmd.word[7:4];
  assign n   = q_cmd.word[3:0];
  assign kk  = q_cmd.word[7:0];
  assign nnn = q_cmd.word[11:0];
  assign vx  = vreg[x];
  assign vy  = vreg[y];
  assign pc1 = 12'(({20'd0, pc} + 32'd1) & {20'd0, 12'(AMASK)});
  assign pc2 = 12'(({20'd0, pc} + 32'd2) & {20'd0, 12'(AMASK)});
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign sp_dec = (sp == '0) ? SW'(STACK_DEPTH - 1) : sp - SW'(1);
  assign sp_inc = (sp == SW'(STACK_DEPTH - 1)) ? '0 : sp + SW'(1);
  assign exec_go = (state == c8x_pkg::ST_EXEC) && q_valid && can_emit;
  assign exec_halt = !q_cmd.undef && (op == c8x_pkg::OP_MISC)
                     && (kk == c8x_pkg::MISC_HALT);

  function automatic logic [11:0] wrapa(input logic [12:0] a);
    wrapa = 12'(a) & 12'(AMASK);
  endfunction

  // Next pc of the instruction at the head.
  always_comb begin
    nxt = pc1;
    if (!q_cmd.undef) begin
      unique case (op)
        c8x_pkg::OP_SYS:  nxt = wrapa({1'b0, rstack[sp_dec]});
        c8x_pkg::OP_JP, c8x_pkg::OP_CALL: nxt = wrapa({1'b0, nnn});
        c8x_pkg::OP_SE:   if (vx == kk) nxt = pc2;
        c8x_pkg::OP_SNE:  if (vx != kk) nxt = pc2;
        c8x_pkg::OP_SER:  if (vx == vy) nxt = pc2;
        c8x_pkg::OP_SNER: if (vx != vy) nxt = pc2;
        c8x_pkg::OP_JPV:  nxt = wrapa({1'b0, nnn} + {5'd0, vreg[0]});
        default: nxt = pc1;
      endcase
    end
  end

  // ALU result of 8xyn and the VF flag where the code sets one.
  always_comb begin
    alu_res  = vy;
    alu_flag = 1'b0;
    alu_wf   = 1'b0;
    unique case (n)
      c8x_pkg::ALU_MOV: alu_res = vy;
      c8x_pkg::ALU_OR:  alu_res = vx | vy;
      c8x_pkg::ALU_AND: alu_res = vx & vy;
      c8x_pkg::ALU_XOR: alu_res = vx ^ vy;
      c8x_pkg::ALU_ADD: begin
        alu_res  = sum9[7:0];
        alu_flag = sum9[8];
        alu_wf   = 1'b1;
      end
      c8x_pkg::ALU_SUB: begin
        alu_res  = vx - vy;
        alu_flag = vx > vy;
        alu_wf   = 1'b1;
      end
      c8x_pkg::ALU_SHR: begin
        alu_res  = {1'b0, vx[7:1]};
        alu_flag = vx[0];
        alu_wf   = 1'b1;
      end
      c8x_pkg::ALU_SBN: begin
        alu_res  = vy - vx;
        alu_flag = vy > vx;
        alu_wf   = 1'b1;
      end
      c8x_pkg::ALU_SHL: begin
        alu_res  = {vx[6:0], 1'b0};
        alu_flag = vx[7];
        alu_wf   = 1'b1;
      end
      default: ;
    endcase
  end

  // BCD digits by compare and subtract for hundreds and a reciprocal multiply for tens.
  always_comb begin
    if (bcd_val >= c8x_pkg::TWO_HUNDRED) begin
      bcd_hund = 2'd2;
      bcd_rem  = bcd_val - c8x_pkg::TWO_HUNDRED;
    end else if (bcd_val >= c8x_pkg::HUNDRED) begin
      bcd_hund = 2'd1;
      bcd_rem  = bcd_val - c8x_pkg::HUNDRED;
    end else begin
      bcd_hund = 2'd0;
      bcd_rem  = bcd_val;
    end
    bcd_prod = 15'(bcd_rem) * c8x_pkg::TEN_RECIP;
    bcd_tens = 4'(bcd_prod >> c8x_pkg::TEN_SHIFT);
    bcd_ones = 4'(bcd_rem - 8'(bcd_tens) * c8x_pkg::TEN);
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      c8x_pkg::ST_EXEC: begin
        if (exec_go && !halt && !q_cmd.undef && op == c8x_pkg::OP_MISC) begin
          if (kk == c8x_pkg::MISC_BCD) state_next = c8x_pkg::ST_BCD;
          else if (kk == c8x_pkg::MISC_STR) state_next = c8x_pkg::ST_STORE;
        end
      end
      c8x_pkg::ST_BCD, c8x_pkg::ST_STORE: begin
        if (can_emit && cnt == cnt_end) state_next = c8x_pkg::ST_EXEC;
      end
      default: state_next = c8x_pkg::ST_EXEC;
    endcase
  end

  assign q_pop = exec_go;

  always_ff @(posedge clk) begin
    if (rst) state <= c8x_pkg::ST_EXEC;
    else     state <= state_next;
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (can_emit) begin
      out_full <= exec_go && !(state_next != c8x_pkg::ST_EXEC)
                  || (state != c8x_pkg::ST_EXEC);
    end
  end

  // Execution, state updates and result payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
      for (int i = 0; i < STACK_DEPTH; i++) rstack[i] <= 12'd0;
      ireg   <= 12'd0;
      pc     <= wrapa({1'b0, cfg_start});
      sp     <= '0;
      dtimer <= 8'd0;
      halt   <= 1'b0;
      cnt    <= 4'd0;
    end else begin
      if (cfg_start_we) pc <= wrapa({1'b0, cfg_start});
      if (state != c8x_pkg::ST_EXEC && can_emit) begin
        // One write of a BCD or store run per cycle while the output can take it.
        next_pc       <= run_pc;
        halted        <= 1'b0;
        write_valid   <= 1'b1;
        write_address <= wrapa({1'b0, ireg} + {9'd0, cnt});
        not_executed  <= 1'b0;
        last          <= (cnt == cnt_end);
        if (state == c8x_pkg::ST_BCD) begin
          if (cnt == 4'd0)      write_data <= {6'd0, bcd_hund};
          else if (cnt == 4'd1) write_data <= {4'd0, bcd_tens};
          else                  write_data <= {4'd0, bcd_ones};
        end else begin
          write_data <= vreg[cnt];
        end
        cnt <= cnt + 4'd1;
      end else if (exec_go && halt) begin
        next_pc       <= pc;
        halted        <= 1'b1;
        write_valid   <= 1'b0;
        write_address <= 12'd0;
        write_data    <= 8'd0;
        not_executed  <= 1'b0;
        last          <= 1'b1;
      end else if (exec_go) begin
        pc            <= nxt;
        run_pc        <= nxt;
        next_pc       <= nxt;
        halted        <= exec_halt;
        write_valid   <= 1'b0;
        write_address <= 12'd0;
        write_data    <= 8'd0;
        not_executed  <= q_cmd.undef;
        last          <= 1'b1;
        cnt           <= 4'd0;
        bcd_val       <= vx;
        if (!q_cmd.undef) begin
          unique case (op)
            c8x_pkg::OP_SYS:  sp <= sp_dec;
            c8x_pkg::OP_CALL: begin
              rstack[sp] <= pc1;
              sp <= sp_inc;
            end
            c8x_pkg::OP_LD:  vreg[x] <= kk;
            c8x_pkg::OP_ADD: vreg[x] <= vx + kk;
            c8x_pkg::OP_RND: vreg[x] <= random_stand_in & kk;
            c8x_pkg::OP_LDI: ireg <= wrapa({1'b0, nnn});
            c8x_pkg::OP_ALU: begin
              // When x is F and the code sets a flag, the flag wins over the result.
              if (alu_wf) vreg[15] <= {7'd0, alu_flag};
              if (!alu_wf || x != 4'hF) vreg[x] <= alu_res;
            end
            c8x_pkg::OP_MISC: begin
              unique case (kk)
                c8x_pkg::MISC_HALT: halt <= 1'b1;
                c8x_pkg::MISC_GDT:  vreg[x] <= dtimer;
                c8x_pkg::MISC_SDT:  dtimer <= vx;
                c8x_pkg::MISC_ADDI: ireg <= wrapa({1'b0, ireg} + {5'd0, vx});
                c8x_pkg::MISC_BCD:  cnt_end <= 4'd2;
                c8x_pkg::MISC_STR:  cnt_end <= x;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
    end
  end

endmodule

FILE: src/chip8_instruction_execute_top.sv
// CHIP-8 instruction execute block: the user-facing top level.
// Channels: in_valid/in_stall carry instruction_word, the instruction at the
// current program counter; out_valid/out_stall carry one result per transfer.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 sets start_address and reloads the program counter, index 1 sets
// the byte used by Cxkk. Writes are meant for idle periods only.
// Path: an accepted instruction is held in the queue, and its result is registered
// in the output register when the back end takes it from the queue head.
// Throughput: one instruction per cycle for ordinary codes while out_stall is low,
// set by the single register-file execute step; Fx33 takes one decode step and three
// writes and Fx55 one decode step and x+1 writes, one memory-write result per cycle.
// A two-entry queue sits between the front and the back end, so up to two instructions
// are still accepted while a result waits in the output register.
// Reset clears V, I, the stack, the timer and halt, and loads the program
// counter with zero; nothing is cleared over extra cycles.
// When out_stall is high the result holds, the queue fills and in_stall rises.
// Depends on c8x_pkg, c8x_front and c8x_back.
module chip8_instruction_execute_top #(
  parameter int STACK_DEPTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] instruction_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] next_pc,
  output logic        halted,
  output logic        write_valid,
  output logic [11:0] write_address,
  output logic [7:0]  write_data,
  output logic        not_executed,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  c8x_pkg::c8x_cmd_t q_cmd;
  logic        q_valid;
  logic        q_pop;
  logic        cfg_we;
  logic [7:0]  random_stand_in;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Configuration register; start_address goes straight into the program counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      random_stand_in <= c8x_pkg::RANDOM_INIT;
    end else if (cfg_we && cfg_index == c8x_pkg::CFG_RANDOM) begin
      random_stand_in <= cfg_data[7:0];
    end
  end

  c8x_front u_front (
    .clk, .rst, .in_valid, .in_stall, .instruction_word,
    .q_valid, .q_cmd, .q_pop
  );

  c8x_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop,
    .cfg_start_we(cfg_we && cfg_index == c8x_pkg::CFG_START),
    .cfg_start(rst ? 12'd0 : cfg_data),
    .random_stand_in,
    .out_valid, .out_stall, .next_pc, .halted, .write_valid,
    .write_address, .write_data, .not_executed, .last
  );

endmodule

FILE: src/c8x_checker.sv
// Port-level checker for the CHIP-8 execute block, bound to the top level.
// Depends on chip8_instruction_execute_top ports only.
module c8x_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        halted,
  input logic        write_valid,
  input logic [11:0] write_address,
  input logic [7:0]  write_data,
  input logic        not_executed,
  input logic        last
);

  // A held result does not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(write_data) && $stable(last))
    else $error("stalled result changed");

  // A write result is never flagged as not executed.
  a_wr_ne: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid |-> !not_executed)
    else $error("write flagged not executed");

  // A result without a write always closes its instruction.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_valid |-> last)
    else $error("non-write result not last");

  // Consecutive writes of a run step the address by one.
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_valid && !last && !out_stall ##1 out_valid
      |-> write_address == $past(write_address) + 12'd1)
    else $error("write run address skipped");

  // Once halted, results carry no write.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !write_valid)
    else $error("write after halt");

endmodule

bind chip8_instruction_execute_top c8x_checker u_checker (.*);
